// ----- hdl/pps_pkg.sv -----
`default_nettype none

package pps_pkg;

  // Number of output resources (buzzer, lamps).
  localparam int NUM_OUTPUTS = 5;
  localparam int IDX_W       = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;

  // Fixed field widths.
  localparam int OP_W       = 2;
  localparam int CH_W       = 3;
  localparam int LEN_W      = 16;
  localparam int TIME_W     = 32;
  localparam int SLOT_W     = 2;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 8;

  // Pattern row: pulses 0..2, end pause, gap.
  localparam int PAT_WORDS = 5;
  localparam int PAT_IDX_W = 3;
  localparam logic [PAT_IDX_W-1:0] P_TAIL = 3'd3;
  localparam logic [PAT_IDX_W-1:0] P_GAP  = 3'd4;

  // Slot index that holds the end pause.
  localparam logic [SLOT_W-1:0] SLOT_TAIL = 2'd3;

  typedef enum logic [OP_W-1:0] {
    OP_PATTERN = 2'd0,
    OP_BLINK   = 2'd1,
    OP_OFF     = 2'd2
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [CH_W-1:0]   channel;
    logic [LEN_W-1:0]  first_len;
    logic [LEN_W-1:0]  second_len;
    logic [LEN_W-1:0]  third_len;
    logic [LEN_W-1:0]  gap_len;
    logic [LEN_W-1:0]  tail_len;
    logic [TIME_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic              level;
    logic [TIME_W-1:0] last_ms;
    logic              pulse_done;
    logic              running;
    logic [SLOT_W-1:0] slot;
  } chan_state_t;

  typedef logic [PAT_WORDS-1:0][LEN_W-1:0] pattern_t;

  typedef struct packed {
    logic [CH_W-1:0] out_channel;
    logic            level;
    logic            went_on;
    logic            went_off;
    logic            pattern_finished;
  } result_t;

  // Update request from the step logic to the channel store.
  typedef struct packed {
    logic        state_we;
    chan_state_t state;
    logic        pat_we;
    pattern_t    pattern;
  } chan_wr_t;

endpackage

`default_nettype wire

// ----- hdl/pps_chan_state.sv -----
`default_nettype none

// Per-channel state flops and latched pattern rows.
module pps_chan_state (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [pps_pkg::IDX_W-1:0] idx_i,
  output pps_pkg::chan_state_t           rd_state_o,
  output pps_pkg::pattern_t              rd_pat_o,
  input  wire logic                      wr_en_i,
  input  wire pps_pkg::chan_wr_t         wr_i
);

  pps_pkg::chan_state_t state_q [pps_pkg::NUM_OUTPUTS];
  pps_pkg::pattern_t    pat_q   [pps_pkg::NUM_OUTPUTS];

  assign rd_state_o = state_q[idx_i];
  assign rd_pat_o   = pat_q[idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pps_pkg::NUM_OUTPUTS; i++) begin
        state_q[i] <= '0;
      end
    end else if (wr_en_i && wr_i.state_we) begin
      state_q[idx_i] <= wr_i.state;
    end
  end

  // Pattern rows are written before first use; no reset.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_i.pat_we) begin
      pat_q[idx_i] <= wr_i.pattern;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pps_step.sv -----
`default_nettype none

// One step of a channel: pattern latch, blink, slot advance, end pause.
module pps_step (
  input  wire pps_pkg::item_t       item_i,
  input  wire logic                 in_range_i,
  input  wire pps_pkg::chan_state_t cur_i,
  input  wire pps_pkg::pattern_t    row_i,
  output pps_pkg::chan_wr_t         wr_o,
  output pps_pkg::result_t          res_o
);

  pps_pkg::op_e                  op;
  pps_pkg::pattern_t             pat;
  pps_pkg::chan_state_t          nxt;
  logic [pps_pkg::TIME_W-1:0]    elapsed;
  logic [pps_pkg::LEN_W-1:0]     slot_len;
  logic [pps_pkg::LEN_W-1:0]     bl_pulse;
  logic [pps_pkg::LEN_W-1:0]     bl_gap;
  logic                          bl_en;
  logic                          is_pat;
  logic                          at_tail;
  logic                          fon;
  logic                          foff;
  logic                          done;

  assign op      = pps_pkg::op_e'(item_i.opcode);
  assign is_pat  = (op == pps_pkg::OP_PATTERN);
  assign at_tail = (cur_i.slot == pps_pkg::SLOT_TAIL);
  assign elapsed = item_i.now_ms - cur_i.last_ms;

  // First pattern step latches the row from the item.
  always_comb begin
    if (cur_i.running) begin
      pat = row_i;
    end else begin
      pat[0]              = item_i.first_len;
      pat[1]              = item_i.second_len;
      pat[2]              = item_i.third_len;
      pat[pps_pkg::P_TAIL] = item_i.tail_len;
      pat[pps_pkg::P_GAP]  = item_i.gap_len;
    end
  end

  assign slot_len = pat[pps_pkg::PAT_IDX_W'(cur_i.slot)];
  assign bl_en    = (op == pps_pkg::OP_BLINK) ||
                    (is_pat && !at_tail && (slot_len != '0));
  assign bl_pulse = (op == pps_pkg::OP_BLINK) ? item_i.first_len : slot_len;
  assign bl_gap   = (op == pps_pkg::OP_BLINK) ? item_i.gap_len : pat[pps_pkg::P_GAP];

  always_comb begin
    nxt  = cur_i;
    fon  = 1'b0;
    foff = 1'b0;
    done = 1'b0;

    if (is_pat) begin
      nxt.running = 1'b1;
    end

    if (bl_en) begin
      if (!cur_i.level && (elapsed >= pps_pkg::TIME_W'(bl_gap)) && (bl_pulse != '0)) begin
        nxt.level   = 1'b1;
        nxt.last_ms = item_i.now_ms;
        fon         = 1'b1;
      end else if (cur_i.level &&
                   ((elapsed >= pps_pkg::TIME_W'(bl_pulse)) || (bl_pulse == '0))) begin
        nxt.level      = 1'b0;
        nxt.last_ms    = item_i.now_ms;
        nxt.pulse_done = 1'b1;
        foff           = 1'b1;
      end
    end

    if (is_pat) begin
      if (at_tail && (elapsed > pps_pkg::TIME_W'(pat[pps_pkg::P_TAIL]))) begin
        // end pause over: pattern finished
        nxt.slot    = '0;
        nxt.running = 1'b0;
        done        = 1'b1;
        if (nxt.level) begin
          nxt.level = 1'b0;
          foff      = 1'b1;
        end
      end else if (nxt.pulse_done || (slot_len == '0)) begin
        if (!at_tail) begin
          nxt.slot = cur_i.slot + 1'b1;
        end
        nxt.pulse_done = 1'b0;
        if (nxt.level) begin
          nxt.level = 1'b0;
          foff      = 1'b1;
        end
      end
    end

    if (op == pps_pkg::OP_OFF) begin
      if (cur_i.level) begin
        nxt.level = 1'b0;
        foff      = 1'b1;
      end
    end
  end

  always_comb begin
    wr_o.state_we = in_range_i;
    wr_o.state    = nxt;
    wr_o.pat_we   = in_range_i && is_pat && !cur_i.running;
    wr_o.pattern  = pat;

    res_o.out_channel      = item_i.channel;
    res_o.level            = in_range_i && nxt.level;
    res_o.went_on          = in_range_i && fon;
    res_o.went_off         = in_range_i && foff;
    res_o.pattern_finished = in_range_i && done;
  end

endmodule

`default_nettype wire

// ----- hdl/pulse_pattern_sequencer_core.sv -----
`default_nettype none

// Channel   Dir  Accepted when            Payload
// s_axis    in   tvalid & tready          tuser opcode, tdata item fields
// m_axis    out  tvalid & tready          tdata result fields
//
// One item per cycle sustained while the output is not stalled; an input transfer
// goes into the input register, then through the step logic into the result register.
// The step reads and writes one channel's flops in the same cycle, so items to
// the same channel may follow back to back.
// Reset clears all channel state; pattern rows are latched on first use.
// A stalled output holds its result; the input register keeps taking items
// as long as the result register can move.
module pulse_pattern_sequencer_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // s_axis
  input  wire logic                           s_axis_tvalid_i,
  output      logic                           s_axis_tready_o,
  // [2:0] channel, [18:3] first_len, [34:19] second_len, [50:35] third_len,
  // [66:51] gap_len, [82:67] tail_len, [114:83] now_ms, [119:115] zero
  input  wire logic [pps_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // [1:0] opcode
  input  wire logic [pps_pkg::OP_W-1:0]       s_axis_tuser_i,
  // m_axis
  output      logic                           m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // [2:0] out_channel, [3] level, [4] went_on, [5] went_off,
  // [6] pattern_finished, [7] zero
  output      logic [pps_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  pps_pkg::item_t       in_item;
  pps_pkg::item_t       in_q;
  logic                 in_valid_q;
  logic                 advance;
  logic                 in_range;
  logic [pps_pkg::IDX_W-1:0] idx;
  pps_pkg::chan_state_t cur_state;
  pps_pkg::pattern_t    cur_row;
  pps_pkg::chan_wr_t    chan_wr;
  pps_pkg::result_t     res_d;
  pps_pkg::result_t     res_q;
  logic                 out_valid_q;

  // Unpack the input transfer.
  assign in_item.opcode     = s_axis_tuser_i;
  assign in_item.channel    = s_axis_tdata_i[2:0];
  assign in_item.first_len  = s_axis_tdata_i[18:3];
  assign in_item.second_len = s_axis_tdata_i[34:19];
  assign in_item.third_len  = s_axis_tdata_i[50:35];
  assign in_item.gap_len    = s_axis_tdata_i[66:51];
  assign in_item.tail_len   = s_axis_tdata_i[82:67];
  assign in_item.now_ms     = s_axis_tdata_i[114:83];

  // Item in the input register moves on when the result register is free.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q <= in_item;
    end
  end

  // Out-of-range channels touch no state and report their channel with level and flags zero.
  assign in_range = (32'(in_q.channel) < pps_pkg::NUM_OUTPUTS);
  assign idx      = pps_pkg::IDX_W'(in_q.channel);

  pps_chan_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .idx_i      (idx),
    .rd_state_o (cur_state),
    .rd_pat_o   (cur_row),
    .wr_en_i    (advance),
    .wr_i       (chan_wr)
  );

  pps_step u_step (
    .item_i     (in_q),
    .in_range_i (in_range),
    .cur_i      (cur_state),
    .row_i      (cur_row),
    .wr_o       (chan_wr),
    .res_o      (res_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, res_q.pattern_finished, res_q.went_off,
                            res_q.went_on, res_q.level, res_q.out_channel};

`ifndef NO_ASSERTIONS
  // A step always lands in the result register on the next edge.
  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("step result not registered");

  // A finished pattern leaves the output off.
  a_done_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.pattern_finished) |-> !res_q.level)
    else $error("pattern finished with output on");

  // Switched on without switching off means the output is on.
  a_on_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.went_on && !res_q.went_off) |-> res_q.level)
    else $error("went_on without level");

  // Out-of-range channels report nothing.
  a_range_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !in_range) |-> (res_d[3:0] == 4'b0000))
    else $error("out-of-range channel reported activity");
`endif

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
module tb_top;
  import pps_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RAND_ITEMS  = 2000;
  localparam int STALL_LIMIT = 4000;

  // Stimulus entry: either an item or a marker that makes the driver hold
  // off until every outstanding result has been transferred.
  typedef struct {
    logic  drain;
    item_t it;
  } stim_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [OP_W-1:0]       s_axis_tuser_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  stim_t   stim_q[$];
  result_t expected_status_q[$];

  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned stall_cycles = 0;
  int          bad_results  = 0;
  int          total_items  = 0;
  int          send_idle_pct;
  logic [1:0]  idle_phase   = 2'd0;

  // Lamp model state, one entry per output.
  logic              lamp_q  [NUM_OUTPUTS];
  logic [TIME_W-1:0] sw_ms_q [NUM_OUTPUTS];
  logic              pdone_q [NUM_OUTPUTS];
  logic              run_q   [NUM_OUTPUTS];
  logic [SLOT_W-1:0] slot_q  [NUM_OUTPUTS];
  pattern_t          row_q   [NUM_OUTPUTS];

  pulse_pattern_sequencer_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    // [2:0] channel, [18:3] first_len, [34:19] second_len, [50:35] third_len,
    // [66:51] gap_len, [82:67] tail_len, [114:83] now_ms, [119:115] zero
    .s_axis_tdata_i  (s_axis_tdata_i),
    // [1:0] opcode
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    // [2:0] out_channel, [3] level, [4] went_on, [5] went_off,
    // [6] pattern_finished, [7] zero
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Lamp model
  // ---------------------------------------------------------------------
  // Switch off: flags only if the lamp was on; switch time is untouched.
  task automatic lamp_off(input int unsigned ch, inout logic off_f);
    if (lamp_q[ch]) begin
      lamp_q[ch] = 1'b0;
      off_f      = 1'b1;
    end
  endtask

  // One blink step: on after the gap, off after the pulse.
  task automatic blink_lamp(input int unsigned ch, input logic [LEN_W-1:0] pulse,
                            input logic [LEN_W-1:0] gap, input logic [TIME_W-1:0] now,
                            inout logic on_f, inout logic off_f);
    logic [TIME_W-1:0] el;
    el = now - sw_ms_q[ch];
    if (!lamp_q[ch] && el >= gap && pulse != '0) begin
      lamp_q[ch]  = 1'b1;
      on_f        = 1'b1;
      sw_ms_q[ch] = now;
    end else if (lamp_q[ch] && (el >= pulse || pulse == '0)) begin
      lamp_q[ch]  = 1'b0;
      off_f       = 1'b1;
      sw_ms_q[ch] = now;
      pdone_q[ch] = 1'b1;
    end
  endtask

  task automatic step_lamp_model(input item_t it, output result_t res);
    int unsigned       ch;
    logic [SLOT_W-1:0] s;
    logic [LEN_W-1:0]  cur;
    logic [TIME_W-1:0] el;
    logic              on_f;
    logic              off_f;
    logic              fin;
    res             = '0;
    res.out_channel = it.channel;
    on_f            = 1'b0;
    off_f           = 1'b0;
    fin             = 1'b0;
    // Out-of-range channels change nothing and report only their channel, all else zero.
    if (it.channel < NUM_OUTPUTS) begin
      ch = it.channel;
      case (it.opcode)
        OP_PATTERN: begin
          // Pattern row is latched only when a pattern starts.
          if (!run_q[ch]) begin
            run_q[ch]         = 1'b1;
            row_q[ch][0]      = it.first_len;
            row_q[ch][1]      = it.second_len;
            row_q[ch][2]      = it.third_len;
            row_q[ch][P_TAIL] = it.tail_len;
            row_q[ch][P_GAP]  = it.gap_len;
          end
          s   = slot_q[ch];
          cur = row_q[ch][s];
          el  = it.now_ms - sw_ms_q[ch];
          if (s == SLOT_TAIL && el > row_q[ch][P_TAIL]) begin
            slot_q[ch] = '0;
            run_q[ch]  = 1'b0;
            lamp_off(ch, off_f);
            fin = 1'b1;
          end else begin
            if (s != SLOT_TAIL && cur != '0) begin
              blink_lamp(ch, cur, row_q[ch][P_GAP], it.now_ms, on_f, off_f);
            end
            // Finished pulse or empty slot: move on, lamp off.
            if (pdone_q[ch] || cur == '0) begin
              if (s != SLOT_TAIL) slot_q[ch] = s + 1'b1;
              pdone_q[ch] = 1'b0;
              lamp_off(ch, off_f);
            end
          end
        end
        OP_BLINK: blink_lamp(ch, it.first_len, it.gap_len, it.now_ms, on_f, off_f);
        OP_OFF:   lamp_off(ch, off_f);
        default: ;
      endcase
      res.level            = lamp_q[ch];
      res.went_on          = on_f;
      res.went_off         = off_f;
      res.pattern_finished = fin;
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic add_item(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                          input logic [LEN_W-1:0] a, input logic [LEN_W-1:0] b,
                          input logic [LEN_W-1:0] c, input logic [LEN_W-1:0] g,
                          input logic [LEN_W-1:0] t, input logic [TIME_W-1:0] now);
    stim_t e;
    e.drain         = 1'b0;
    e.it.opcode     = op;
    e.it.channel    = ch;
    e.it.first_len  = a;
    e.it.second_len = b;
    e.it.third_len  = c;
    e.it.gap_len    = g;
    e.it.tail_len   = t;
    e.it.now_ms     = now;
    stim_q.push_back(e);
    total_items++;
  endtask

  task automatic add_drain();
    stim_t e;
    e.drain = 1'b1;
    e.it    = '0;
    stim_q.push_back(e);
  endtask

  // Short pulse length, empty slot one time in four.
  function automatic logic [LEN_W-1:0] short_len();
    return ($urandom_range(0, 3) == 0) ? LEN_W'(0) : LEN_W'($urandom_range(1, 12));
  endfunction

  // ---------------------------------------------------------------------
  // Driver: one transfer per handshake, random gaps by phase
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drv
    int unsigned issued;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      items_sent      <= 0;
      idle_phase      <= 2'd0;
      issued          = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) items_sent <= items_sent + 1;
      // Sender idles lightly first, heavily next, then not at all.
      if (issued < total_items / 3) begin
        send_idle_pct = 16;
        idle_phase   <= 2'd0;
      end else if (issued < (2 * total_items) / 3) begin
        send_idle_pct = 86;
        idle_phase   <= 2'd1;
      end else begin
        send_idle_pct = 0;
        idle_phase   <= 2'd2;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (stim_q.size() != 0 && stim_q[0].drain) begin
          s_axis_tvalid_i <= 1'b0;
          // Hold until the bus is empty and all results are back.
          if (!s_axis_tvalid_i && results_seen == items_sent) void'(stim_q.pop_front());
        end else if (stim_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_axis_tdata_i  <= {5'd0, stim_q[0].it.now_ms, stim_q[0].it.tail_len,
                              stim_q[0].it.gap_len, stim_q[0].it.third_len,
                              stim_q[0].it.second_len, stim_q[0].it.first_len,
                              stim_q[0].it.channel};
          s_axis_tuser_i  <= stim_q[0].it.opcode;
          s_axis_tvalid_i <= 1'b1;
          void'(stim_q.pop_front());
          issued++;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure, mirrored against the sender phases.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      case (idle_phase)
        2'd0:    m_axis_tready_i <= ($urandom_range(0, 99) >= 86);
        2'd1:    m_axis_tready_i <= ($urandom_range(0, 99) >= 16);
        default: m_axis_tready_i <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: predict on input transfer, check on output transfer
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : mon
    item_t   in_it;
    result_t got;
    result_t want;
    result_t pred;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.out_channel      = m_axis_tdata_o[2:0];
        got.level            = m_axis_tdata_o[3];
        got.went_on          = m_axis_tdata_o[4];
        got.went_off         = m_axis_tdata_o[5];
        got.pattern_finished = m_axis_tdata_o[6];
        results_seen <= results_seen + 1;
        if (expected_status_q.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("unexpected result: ch %0d lvl %0b on %0b off %0b fin %0b",
                     got.out_channel, got.level, got.went_on, got.went_off,
                     got.pattern_finished);
        end else begin
          want = expected_status_q.pop_front();
          if (got.out_channel != want.out_channel || got.level != want.level ||
              got.went_on != want.went_on || got.went_off != want.went_off ||
              got.pattern_finished != want.pattern_finished) begin
            bad_results++;
            if (bad_results <= 10)
              $display("result mismatch: exp ch %0d lvl %0b on %0b off %0b fin %0b, got ch %0d lvl %0b on %0b off %0b fin %0b",
                       want.out_channel, want.level, want.went_on, want.went_off,
                       want.pattern_finished, got.out_channel, got.level, got.went_on,
                       got.went_off, got.pattern_finished);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_it.opcode     = s_axis_tuser_i;
        in_it.channel    = s_axis_tdata_i[2:0];
        in_it.first_len  = s_axis_tdata_i[18:3];
        in_it.second_len = s_axis_tdata_i[34:19];
        in_it.third_len  = s_axis_tdata_i[50:35];
        in_it.gap_len    = s_axis_tdata_i[66:51];
        in_it.tail_len   = s_axis_tdata_i[82:67];
        in_it.now_ms     = s_axis_tdata_i[114:83];
        step_lamp_model(in_it, pred);
        expected_status_q.push_back(pred);
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin : main
    logic [TIME_W-1:0] chan_ms [NUM_OUTPUTS];
    logic [CH_W-1:0]   ch;
    logic [OP_W-1:0]   op;
    int                n_rand;
    int                pick;
    int                burst;
    logic              drained;

    for (int i = 0; i < NUM_OUTPUTS; i++) begin
      lamp_q[i]  = 1'b0;
      sw_ms_q[i] = '0;
      pdone_q[i] = 1'b0;
      run_q[i]   = 1'b0;
      slot_q[i]  = '0;
      row_q[i]   = '0;
      chan_ms[i] = $urandom;
    end
    // Output 0 runs across the 32-bit time wrap.
    chan_ms[0] = 32'hFFFF_FF00;

    // Directed: all-ones pattern that waits on its gap.
    add_item(OP_PATTERN, 3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0);
    // Blink with zero pulse never lights; then on at max time, off across the wrap.
    add_item(OP_BLINK, 3'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd0);
    add_item(OP_BLINK, 3'd1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    add_item(OP_BLINK, 3'd1, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd0);
    // Force off while already off, then while on.
    add_item(OP_OFF, 3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd5);
    add_item(OP_BLINK, 3'd2, 16'h0005, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd100);
    add_item(OP_OFF, 3'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd101);
    // Unused opcode and out-of-range channels.
    add_item(OP_UNUSED, 3'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd102);
    add_item(OP_PATTERN, 3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    add_item(OP_BLINK, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    // All slots empty with zero end pause: walk to the tail and finish.
    for (int k = 0; k < 4; k++)
      add_item(OP_PATTERN, 3'd3, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd10 + k / 3);
    // Full pattern with an empty middle slot, run to completion.
    for (int k = 0; k < 9; k++)
      add_item(OP_PATTERN, 3'd4, 16'd2, 16'd0, 16'd3, 16'd1, 16'd4, 32'd1000 + 2 * k);
    // Pending pulse-done from a blink: pattern start lights and clears in one step.
    add_item(OP_BLINK, 3'd1, 16'd3, 16'd0, 16'd0, 16'd0, 16'd0, 32'd200);
    add_item(OP_BLINK, 3'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd201);
    add_item(OP_PATTERN, 3'd1, 16'd5, 16'd1, 16'd1, 16'd0, 16'd2, 32'd202);
    add_drain();

    // Random: mostly bursts of pattern steps with slowly advancing time.
    n_rand  = 0;
    drained = 1'b0;
    while (n_rand < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        ch    = CH_W'($urandom_range(0, NUM_OUTPUTS - 1));
        op    = (pick < 62) ? OP_PATTERN : OP_BLINK;
        burst = $urandom_range(1, 8);
        for (int k = 0; k < burst; k++) begin
          chan_ms[ch] = chan_ms[ch] + $urandom_range(0, 6);
          add_item(op, ch, short_len(), short_len(), short_len(),
                   LEN_W'($urandom_range(0, 8)), LEN_W'($urandom_range(0, 16)),
                   chan_ms[ch]);
        end
        n_rand += burst;
      end else if (pick < 90) begin
        ch = CH_W'($urandom_range(0, NUM_OUTPUTS - 1));
        add_item(OP_OFF, ch, short_len(), short_len(), short_len(), 16'd0, 16'd0, chan_ms[ch]);
        n_rand++;
      end else begin
        // Noise: any opcode, any channel, any field value.
        add_item(OP_W'($urandom_range(0, 3)), CH_W'($urandom_range(0, 7)),
                 LEN_W'($urandom), LEN_W'($urandom), LEN_W'($urandom),
                 LEN_W'($urandom), LEN_W'($urandom), $urandom);
        n_rand++;
      end
      if (!drained && n_rand >= RAND_ITEMS / 2) begin
        add_drain();
        drained = 1'b1;
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || s_axis_tvalid_i || results_seen != items_sent)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    bad_results = bad_results + expected_status_q.size();
    if (bad_results == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
